[src/rpcr_pkg.sv]
// Shared types, codes and constant tables of the rotation period capture responder.
package rpcr_pkg;

    // Input transaction kinds
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_EDGE = 2'd1;
    localparam logic [1:0] REQ_BYTE = 2'd2;

    // Answer error codes
    localparam logic [7:0] ERR_OK   = 8'd0;
    localparam logic [7:0] ERR_CSUM = 8'd1;
    localparam logic [7:0] ERR_CMD  = 8'd2;

    // Command codes
    localparam logic [7:0] CMD_REV     = 8'd0;
    localparam logic [7:0] CMD_ZERO_A  = 8'd1;
    localparam logic [7:0] CMD_ZERO_B  = 8'd2;
    localparam logic [7:0] CMD_PERIODS = 8'd3;

    localparam int unsigned REV_LEN = 5;

    // Datapath commands from the controller
    typedef struct packed {
        logic take_in;   // apply the accepted input transaction
        logic idx_clr;   // answer index to 0
        logic idx_one;   // answer index to 1
        logic idx_inc;   // answer index + 1
        logic acc_clr;   // clear checksum accumulator
        logic acc_en;    // add current answer byte to accumulator
        logic pkt_clr;   // clear packet sum, command and byte count
    } t_dp_cmd;

    // Datapath status to the controller
    typedef struct packed {
        logic in_last;   // input is the last packet byte
        logic idx_end;   // answer index at final byte
    } t_dp_stat;

    // ASCII "$Rev$"
    function automatic logic [7:0] rev_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h24;
            3'd1:    ch = 8'h52;
            3'd2:    ch = 8'h65;
            3'd3:    ch = 8'h76;
            3'd4:    ch = 8'h24;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

[src/rpcr_if.sv]
// Valid/ready channel interfaces for requests and answer bytes.
interface rpcr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] packet_byte;
    logic       last_byte;

    modport source (output valid, output req_type, output packet_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input req_type, input packet_byte, input last_byte,
                    output ready);
endinterface

interface rpcr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] answer_byte;
    logic       answer_last;

    modport source (output valid, output answer_byte, output answer_last, input ready);
    modport sink   (input valid, input answer_byte, input answer_last, output ready);
endinterface

[src/rpcr_datapath.sv]
// Datapath: tick counters, period ring, packet state and answer byte generation.
module rpcr_datapath #(
    parameter int RING_DEPTH    = 4,
    parameter int PAYLOAD_BYTES = 22,
    parameter int MAX_PACKET    = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_req_type,
    input  logic [7:0]        i_packet_byte,
    input  logic              i_last_byte,
    input  rpcr_pkg::t_dp_cmd i_cmd,
    output rpcr_pkg::t_dp_stat o_stat,
    output logic [7:0]        o_answer_byte
);
    import rpcr_pkg::*;

    localparam int ANS_LEN = PAYLOAD_BYTES + 2;
    localparam int IDX_W   = $clog2(ANS_LEN);
    localparam int BC_W    = $clog2(MAX_PACKET + 1);
    localparam int RP_W    = $clog2(RING_DEPTH);
    localparam int WD_W    = IDX_W - 2;

    logic [15:0]      r_low;
    logic [7:0]       r_high;
    logic [23:0]      r_ring [RING_DEPTH];
    logic [RP_W-1:0]  r_pos;
    logic [7:0]       r_sum;
    logic [7:0]       r_cmd;
    logic [BC_W-1:0]  r_bcnt;
    logic [IDX_W-1:0] r_idx;
    logic [7:0]       r_acc;

    logic [IDX_W-1:0] w_pos;
    logic [WD_W-1:0]  w_word;
    logic [1:0]       w_lane;
    logic [RP_W:0]    w_rsum;
    logic [RP_W:0]    w_ridx;
    logic [31:0]      w_wval;
    logic [31:0]      w_wshift;
    logic [7:0]       w_err;
    logic [7:0]       w_pay;

    // Counters, ring and packet state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '0;
            r_high <= '0;
            r_pos  <= '0;
            r_sum  <= '0;
            r_cmd  <= '0;
            r_bcnt <= '0;
            for (int i = 0; i < RING_DEPTH; i++) begin
                r_ring[i] <= '0;
            end
        end else if (i_cmd.pkt_clr) begin
            r_sum  <= '0;
            r_cmd  <= '0;
            r_bcnt <= '0;
        end else if (i_cmd.take_in) begin
            case (i_req_type)
                REQ_TICK: begin
                    r_low <= r_low + 16'd1;
                    if (r_low == 16'hffff && r_high != 8'hff) begin
                        r_high <= r_high + 8'd1;
                    end
                end
                REQ_EDGE: begin
                    r_ring[r_pos] <= {r_high, r_low};
                    r_pos  <= (r_pos == RP_W'(RING_DEPTH - 1)) ? '0 : r_pos + RP_W'(1);
                    r_low  <= '0;
                    r_high <= '0;
                end
                REQ_BYTE: begin
                    if (r_bcnt < BC_W'(MAX_PACKET)) begin
                        r_sum  <= r_sum + i_packet_byte;
                        r_bcnt <= r_bcnt + BC_W'(1);
                        if (r_bcnt == BC_W'(1)) begin
                            r_cmd <= i_packet_byte;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Answer index and checksum accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_one) begin
            r_idx <= IDX_W'(1);
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc <= r_acc + o_answer_byte;
        end
    end

    // Payload position -> word number and byte lane
    assign w_pos  = r_idx - IDX_W'(2);
    assign w_word = w_pos[IDX_W-1:2];
    assign w_lane = w_pos[1:0];

    // Oldest entry first: ring slot = (write pointer + word) mod depth
    assign w_rsum = {1'b0, r_pos} + (RP_W+1)'(w_word);
    assign w_ridx = (w_rsum >= (RP_W+1)'(RING_DEPTH)) ?
                    w_rsum - (RP_W+1)'(RING_DEPTH) : w_rsum;

    always_comb begin
        if (32'(w_word) < RING_DEPTH) begin
            w_wval = {8'h00, r_ring[w_ridx[RP_W-1:0]]};
        end else if (32'(w_word) == RING_DEPTH) begin
            w_wval = {8'h00, r_high, r_low};
        end else begin
            w_wval = '0;
        end
    end
    assign w_wshift = w_wval >> {w_lane, 3'b000};

    always_comb begin
        if (r_sum != 8'd0) begin
            w_err = ERR_CSUM;
        end else if (r_bcnt < BC_W'(2)) begin
            w_err = ERR_CMD;
        end else if (r_cmd <= CMD_PERIODS) begin
            w_err = ERR_OK;
        end else begin
            w_err = ERR_CMD;
        end
    end

    always_comb begin
        case (r_cmd)
            CMD_REV:     w_pay = (32'(w_pos) < REV_LEN) ? rev_char(w_pos[2:0]) : 8'h00;
            CMD_ZERO_A:  w_pay = 8'h00;
            CMD_ZERO_B:  w_pay = 8'h00;
            CMD_PERIODS: w_pay = w_wshift[7:0];
            default:     w_pay = 8'h00;
        endcase
    end

    always_comb begin
        if (r_idx == '0) begin
            o_answer_byte = 8'd0 - r_acc;
        end else if (r_idx == IDX_W'(1)) begin
            o_answer_byte = w_err;
        end else if (w_err == ERR_OK) begin
            o_answer_byte = w_pay;
        end else begin
            o_answer_byte = 8'h00;
        end
    end

    assign o_stat.in_last = (i_req_type == REQ_BYTE) && i_last_byte;
    assign o_stat.idx_end = (r_idx == IDX_W'(ANS_LEN - 1));

endmodule

[src/rpcr_ctrl.sv]
// Controller: accepts requests, runs the checksum pass and sends the answer.
module rpcr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    input  rpcr_pkg::t_dp_stat i_stat,
    output rpcr_pkg::t_dp_cmd  o_cmd
);
    import rpcr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_SEND
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take_in = 1'b1;
                    if (i_stat.in_last) begin
                        o_cmd.acc_clr = 1'b1;
                        o_cmd.idx_one = 1'b1;
                        n_state       = ST_SUM;
                    end
                end
            end
            ST_SUM: begin
                o_cmd.acc_en = 1'b1;
                if (i_stat.idx_end) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = ST_SEND;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ST_SEND: begin
                if (i_out_ready) begin
                    if (i_stat.idx_end) begin
                        o_cmd.pkt_clr = 1'b1;
                        o_cmd.idx_clr = 1'b1;
                        n_state       = ST_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_SEND);

endmodule

[src/rotation_period_capture_responder_unit.sv]
// Top level of the rotation period capture responder.
//
// Usage: i_req carries one transaction per request: a counter tick, a rotation
// edge, or one byte of a command packet (last_byte marks its end). o_ans
// carries the answer, one byte per transaction, answer_last on the final one.
// Ticks, edges and non-final packet bytes are taken one per cycle while
// i_req.ready is high and may arrive back to back; they produce no answer.
// The final packet byte starts an answer of PAYLOAD_BYTES+2 bytes. The block
// first walks every byte after the checksum byte once to form the checksum
// (one byte per cycle through the shared byte generator), then presents the
// bytes, one per cycle while the receiver is ready. i_req.ready is low from
// the final packet byte until the last answer byte is taken; ticks and edges
// wait upstream during that window.
// A stall on o_ans simply holds the current byte; all state is frozen.
// Reset (synchronous, active low) clears counters, period ring, ring pointer
// and packet state, and drops any answer in progress.
module rotation_period_capture_responder_unit #(
    parameter int RING_DEPTH    = 4,
    parameter int PAYLOAD_BYTES = 22,
    parameter int MAX_PACKET    = 32
) (
    input logic      i_clk,
    input logic      i_rst_n,
    rpcr_in_if.sink  i_req,
    rpcr_out_if.source o_ans
);
    import rpcr_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencer: owns both handshakes
    rpcr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_ans.ready),
        .o_out_valid (o_ans.valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Counters, ring, packet state and answer byte mux
    rpcr_datapath #(
        .RING_DEPTH    (RING_DEPTH),
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .MAX_PACKET    (MAX_PACKET)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_type    (i_req.req_type),
        .i_packet_byte (i_req.packet_byte),
        .i_last_byte   (i_req.last_byte),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_answer_byte (o_ans.answer_byte)
    );

    assign o_ans.answer_last = w_stat.idx_end;

    // Input and answer never open at the same time
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.ready && o_ans.valid))
        else $error("input ready while answer pending");

    // Final packet byte closes the input side
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && i_req.req_type == REQ_BYTE && i_req.last_byte)
        |=> !i_req.ready)
        else $error("input still open after final packet byte");

    // Taking the final answer byte reopens the input side
    a_last_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ans.valid && o_ans.ready && o_ans.answer_last) |=> i_req.ready)
        else $error("input not reopened after final answer byte");

    // Answer starts with the checksum byte and is not marked last there
    a_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_ans.valid) |-> !o_ans.answer_last)
        else $error("answer marked last on its first byte");

endmodule
